[rtl/assert_macros.svh]
// assertion shorthands for the rtl files
// every macro samples on posedge clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mts_pkg.sv]
// shared constants and types of the multi timer scheduler
// no dependencies; imported by mts_alu and multi_timer_scheduler
`default_nettype none

package mts_pkg;

  localparam int NUM_TIMERS  = 10;
  localparam int MAX_RESULTS = 10;
  localparam int DATA_W      = 32;
  localparam int SLOT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
  localparam int IXW         = (SLOT_W > 4) ? SLOT_W : 4;

  // request function codes
  localparam logic [2:0] FN_TICK      = 3'd0;
  localparam logic [2:0] FN_ALLOC     = 3'd1;
  localparam logic [2:0] FN_START     = 3'd2;
  localparam logic [2:0] FN_STOP      = 3'd3;
  localparam logic [2:0] FN_RESET     = 3'd4;
  localparam logic [2:0] FN_SETRELOAD = 3'd5;
  localparam logic [2:0] FN_ELAPSED   = 3'd6;

  // result kinds
  localparam logic [2:0] K_EXPIRED   = 3'd0;
  localparam logic [2:0] K_ALLOCATED = 3'd1;
  localparam logic [2:0] K_NONE_FREE = 3'd2;
  localparam logic [2:0] K_DONE      = 3'd3;
  localparam logic [2:0] K_ELAPSED   = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              carry;
    logic              zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

[rtl/mts_alu.sv]
// shared 32-bit add / subtract unit with carry and zero flags
// depends on mts_pkg
`default_nettype none

module mts_alu (
  input  mts_pkg::alu_req_t req,
  output mts_pkg::alu_rsp_t rsp
);
  import mts_pkg::*;

  logic [DATA_W:0]   full;
  logic [DATA_W-1:0] b_op;

  // subtract as a + ~b + 1, carry set means a >= b
  assign b_op = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_op} + {{DATA_W{1'b0}}, req.sub};

  assign rsp.sum   = full[DATA_W-1:0];
  assign rsp.carry = full[DATA_W];
  assign rsp.zero  = (full[DATA_W-1:0] == '0);

endmodule

`default_nettype wire

[rtl/multi_timer_scheduler.sv]
// top level of the multi timer scheduler: slot state, sequencer, output register
// depends on mts_pkg, mts_alu and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  in_      | in        | in_valid/in_stall  | func, timer_index, value, periodic
//  out_     | out       | out_valid/out_stall| kind, slot, elapsed, last
//
//  one request is taken at a time; in_stall is high until its work is finished
//  commands pass through accept and execute, execute writing the result to the output reg
//  a tick passes increment, a candidate scan of the N slots, then per firing timer a select
//  scan and a fire step, the single shared adder/comparator stepping one slot per cycle
//  a held result (out_stall high) holds the execute and fire steps until it is taken
//  synchronous active-low reset clears the clock, slot flags and control state

module multi_timer_scheduler (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [2:0]                   in_func,
  input  wire  [3:0]                   in_timer_index,
  input  wire  [mts_pkg::DATA_W-1:0]   in_value,
  input  wire                          in_periodic,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [2:0]                   out_kind,
  output logic [3:0]                   out_slot,
  output logic [mts_pkg::DATA_W-1:0]   out_elapsed,
  output logic                         out_last
);
  import mts_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TINC  = 3'd2;
  localparam logic [2:0] S_TCAND = 3'd3;
  localparam logic [2:0] S_TSEL  = 3'd4;
  localparam logic [2:0] S_TFIRE = 3'd5;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

  // control state
  logic [2:0]            state_r, state_nxt;
  logic [SLOT_W-1:0]     scan_r, scan_nxt;
  logic [SLOT_W-1:0]     best_r, best_nxt;
  logic                  have_best_r, have_best_nxt;
  logic [DATA_W-1:0]     best_dl_r, best_dl_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      fired_r, fired_nxt;
  logic [NUM_TIMERS-1:0] cand_r, cand_nxt;

  // timer state
  logic [DATA_W-1:0]     now_r, now_nxt;
  logic [NUM_TIMERS-1:0] slot_used_r, slot_used_nxt;
  logic [NUM_TIMERS-1:0] slot_running_r, slot_running_nxt;
  logic [NUM_TIMERS-1:0] slot_periodic_r, slot_periodic_nxt;
  logic [DATA_W-1:0]     deadline_r [NUM_TIMERS];
  logic [DATA_W-1:0]     reload_r [NUM_TIMERS];

  // per-slot write ports
  logic                  dl_we, rl_we;
  logic [SLOT_W-1:0]     dl_wa, rl_wa;
  logic [DATA_W-1:0]     deadline_nxt, reload_nxt;

  // captured request
  logic [2:0]            func_r, func_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic                  idx_ok_r, idx_ok_nxt;
  logic [DATA_W-1:0]     value_r, value_nxt;
  logic                  per_r, per_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_kind_r, out_kind_nxt;
  logic [3:0]            out_slot_r, out_slot_nxt;
  logic [DATA_W-1:0]     out_elapsed_r, out_elapsed_nxt;
  logic                  out_last_r, out_last_nxt;

  // datapath
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [SLOT_W-1:0]     rd_idx;
  logic [DATA_W-1:0]     dl_rd, rl_rd;
  logic                  out_free;
  logic                  in_take;
  logic [IXW-1:0]        tidx_w;
  logic                  in_range;
  logic [SLOT_W-1:0]     free_idx;
  logic                  free_any;
  logic                  slot_ok;
  logic                  cand_hit;
  logic                  fire_last;
  logic [CNT_W-1:0]      cnt_sum;

  mts_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign tidx_w    = IXW'(in_timer_index);
  assign in_range  = (32'(in_timer_index) < 32'(NUM_TIMERS));

  // one read address serves both slot arrays
  always_comb begin
    if (state_r == S_TCAND || state_r == S_TSEL) begin
      rd_idx = scan_r;
    end else if (state_r == S_TFIRE) begin
      rd_idx = best_r;
    end else begin
      rd_idx = idx_r;
    end
  end
  assign dl_rd = deadline_r[rd_idx];
  assign rl_rd = reload_r[rd_idx];

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end
  assign free_any = ~&slot_used_r;

  assign slot_ok   = idx_ok_r && slot_used_r[idx_r];
  // deadline <= now: a borrow on deadline - now, or a zero result
  assign cand_hit  = slot_running_r[scan_r] && (!alu_rsp.carry || alu_rsp.zero);
  assign fire_last = ((fired_r + CNT_W'(1)) == cnt_r);
  assign cnt_sum   = cnt_r + CNT_W'(cand_hit);

  // operand selection for the shared unit
  always_comb begin
    alu_req.a   = now_r;
    alu_req.b   = value_r;
    alu_req.sub = 1'b0;
    unique case (state_r)
      S_TINC: begin
        alu_req.b = DATA_W'(1);
      end
      S_TCAND: begin
        // deadline - now
        alu_req.a   = dl_rd;
        alu_req.b   = now_r;
        alu_req.sub = 1'b1;
      end
      S_TSEL: begin
        // deadline - best deadline, no carry means strictly lower
        alu_req.a   = dl_rd;
        alu_req.b   = best_dl_r;
        alu_req.sub = 1'b1;
      end
      S_TFIRE: begin
        alu_req.a = dl_rd;
        alu_req.b = rl_rd;
      end
      S_EXEC: begin
        alu_req.b   = (func_r == FN_START || func_r == FN_RESET) ? rl_rd : value_r;
        alu_req.sub = (func_r == FN_ELAPSED);
      end
      default: begin
        alu_req.a = now_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    scan_nxt          = scan_r;
    best_nxt          = best_r;
    have_best_nxt     = have_best_r;
    best_dl_nxt       = best_dl_r;
    cnt_nxt           = cnt_r;
    fired_nxt         = fired_r;
    cand_nxt          = cand_r;
    now_nxt           = now_r;
    slot_used_nxt     = slot_used_r;
    slot_running_nxt  = slot_running_r;
    slot_periodic_nxt = slot_periodic_r;
    func_nxt          = func_r;
    idx_nxt           = idx_r;
    idx_ok_nxt        = idx_ok_r;
    value_nxt         = value_r;
    per_nxt           = per_r;
    dl_we             = 1'b0;
    dl_wa             = idx_r;
    deadline_nxt      = alu_rsp.sum;
    rl_we             = 1'b0;
    rl_wa             = idx_r;
    reload_nxt        = value_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_kind_nxt      = out_kind_r;
    out_slot_nxt      = out_slot_r;
    out_elapsed_nxt   = out_elapsed_r;
    out_last_nxt      = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          func_nxt   = in_func;
          idx_nxt    = in_range ? tidx_w[SLOT_W-1:0] : '0;
          idx_ok_nxt = in_range;
          value_nxt  = in_value;
          per_nxt    = in_periodic;
          state_nxt  = (in_func == FN_TICK) ? S_TINC : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = K_DONE;
          out_slot_nxt    = '0;
          out_elapsed_nxt = '0;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
          unique case (func_r)
            FN_ALLOC: begin
              if (free_any) begin
                slot_used_nxt[free_idx]     = 1'b1;
                slot_running_nxt[free_idx]  = 1'b0;
                slot_periodic_nxt[free_idx] = per_r;
                rl_we        = 1'b1;
                rl_wa        = free_idx;
                reload_nxt   = '0;
                out_kind_nxt = K_ALLOCATED;
                out_slot_nxt = 4'(free_idx);
              end else begin
                out_kind_nxt = K_NONE_FREE;
              end
            end
            FN_START: begin
              if (slot_ok && !slot_running_r[idx_r]) begin
                dl_we                   = 1'b1;
                slot_running_nxt[idx_r] = 1'b1;
              end
            end
            FN_STOP: begin
              if (slot_ok) begin
                slot_running_nxt[idx_r] = 1'b0;
              end
            end
            FN_RESET: begin
              // stop then start always restarts from now
              if (slot_ok) begin
                dl_we                   = 1'b1;
                slot_running_nxt[idx_r] = 1'b1;
              end
            end
            FN_SETRELOAD: begin
              if (slot_ok) begin
                rl_we = 1'b1;
                dl_we = slot_running_r[idx_r];
              end
            end
            FN_ELAPSED: begin
              out_kind_nxt    = K_ELAPSED;
              out_elapsed_nxt = alu_rsp.sum;
            end
            default: begin
              // unknown function gives no result
              out_valid_nxt = out_valid_r && out_stall;
            end
          endcase
        end
      end

      S_TINC: begin
        now_nxt   = alu_rsp.sum;
        scan_nxt  = '0;
        cnt_nxt   = '0;
        fired_nxt = '0;
        cand_nxt  = '0;
        state_nxt = S_TCAND;
      end

      S_TCAND: begin
        cand_nxt[scan_r] = cand_hit;
        cnt_nxt          = cnt_sum;
        if (scan_r == LAST_SLOT) begin
          if (32'(cnt_sum) > 32'(MAX_RESULTS)) begin
            cnt_nxt = CNT_W'(MAX_RESULTS);
          end
          scan_nxt      = '0;
          have_best_nxt = 1'b0;
          state_nxt     = (cnt_sum == '0) ? S_IDLE : S_TSEL;
        end else begin
          scan_nxt = scan_r + SLOT_W'(1);
        end
      end

      S_TSEL: begin
        // earliest deadline, strict compare keeps the lower slot on ties
        if (cand_r[scan_r] && (!have_best_r || !alu_rsp.carry)) begin
          best_nxt      = scan_r;
          best_dl_nxt   = dl_rd;
          have_best_nxt = 1'b1;
        end
        if (scan_r == LAST_SLOT) begin
          state_nxt = S_TFIRE;
        end else begin
          scan_nxt = scan_r + SLOT_W'(1);
        end
      end

      S_TFIRE: begin
        if (out_free) begin
          cand_nxt[best_r] = 1'b0;
          if (slot_periodic_r[best_r]) begin
            dl_we = 1'b1;
            dl_wa = best_r;
          end else begin
            slot_running_nxt[best_r] = 1'b0;
            slot_used_nxt[best_r]    = 1'b0;
          end
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = K_EXPIRED;
          out_slot_nxt    = 4'(best_r);
          out_elapsed_nxt = '0;
          out_last_nxt    = fire_last;
          fired_nxt       = fired_r + CNT_W'(1);
          scan_nxt        = '0;
          have_best_nxt   = 1'b0;
          state_nxt       = fire_last ? S_IDLE : S_TSEL;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      now_r           <= '0;
      slot_used_r     <= '0;
      slot_running_r  <= '0;
      slot_periodic_r <= '0;
      out_valid_r     <= 1'b0;
      cnt_r           <= '0;
      fired_r         <= '0;
      cand_r          <= '0;
      have_best_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      now_r           <= now_nxt;
      slot_used_r     <= slot_used_nxt;
      slot_running_r  <= slot_running_nxt;
      slot_periodic_r <= slot_periodic_nxt;
      out_valid_r     <= out_valid_nxt;
      cnt_r           <= cnt_nxt;
      fired_r         <= fired_nxt;
      cand_r          <= cand_nxt;
      have_best_r     <= have_best_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r        <= scan_nxt;
    best_r        <= best_nxt;
    best_dl_r     <= best_dl_nxt;
    func_r        <= func_nxt;
    idx_r         <= idx_nxt;
    idx_ok_r      <= idx_ok_nxt;
    value_r       <= value_nxt;
    per_r         <= per_nxt;
    out_kind_r    <= out_kind_nxt;
    out_slot_r    <= out_slot_nxt;
    out_elapsed_r <= out_elapsed_nxt;
    out_last_r    <= out_last_nxt;
    if (dl_we) begin
      deadline_r[dl_wa] <= deadline_nxt;
    end
    if (rl_we) begin
      reload_r[rl_wa] <= reload_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_slot    = out_slot_r;
  assign out_elapsed = out_elapsed_r;
  assign out_last    = out_last_r;

  `ASSERT_CLK(a_running_is_used, (slot_running_r & ~slot_used_r) == '0, "running slot not allocated")
  `ASSERT_IMPL(a_fire_within_count, state_r == S_TFIRE, fired_r < cnt_r, "fire beyond expiry count")
  `ASSERT_NEXT(a_tick_advances, state_r == S_TINC, now_r == $past(now_r) + 32'd1, "clock not advanced")

endmodule

`default_nettype wire
